FILE: rtl/core/ept_pkg.sv
package ept_pkg;

    // Field and register widths
    localparam int COUNTER_BITS_DEF = 16;
    localparam int COUNT_W          = 16;
    localparam int DELTA_W          = 16;
    localparam int SPEED_W          = 16;
    localparam int TOTAL_W          = 32;
    localparam int CDEG_W           = 16;
    localparam int ANGLE_W          = 48;
    localparam int FACTOR_W         = 24;
    localparam int PPT_W            = 20;
    localparam int CFG_ADDR_W       = 1;
    localparam int CFG_DATA_W       = 24;

    // Register reset values
    localparam logic [FACTOR_W-1:0] FACTOR_RST = 24'd65536;
    localparam logic [PPT_W-1:0]    PPT_RST    = 20'd1024;

    // Arithmetic constants
    localparam logic [CDEG_W-1:0]         CDEG_PER_TURN = 16'd36000;
    localparam int                        SPEED_POS_MAX = 32767;
    localparam int                        SPEED_NEG_MAG = 32768;
    localparam logic signed [SPEED_W-1:0] SPEED_POS_SAT = 16'sh7FFF;
    localparam logic signed [SPEED_W-1:0] SPEED_NEG_SAT = 16'sh8000;

    // Input mode codes
    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_INIT = 1'b1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_SPEED_FACTOR   = 1'b0,
        CFG_PULSES_PER_TURN = 1'b1
    } cfg_addr_t;

    typedef struct packed {
        logic               mode;
        logic [COUNT_W-1:0] counter_value;
    } in_t;

    typedef struct packed {
        logic signed [DELTA_W-1:0] pulse_delta;
        logic signed [SPEED_W-1:0] shaft_speed;
        logic signed [TOTAL_W-1:0] total_pulses;
        logic [CDEG_W-1:0]         turn_angle_cdeg;
        logic signed [ANGLE_W-1:0] total_angle_cdeg;
    } out_t;

endpackage

FILE: rtl/core/ept_smul.sv
module ept_smul #(
    parameter int AW = 32,
    parameter int BW = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic             busy,
    output logic [AW+BW-1:0] product
);

    localparam int PW = AW + BW;
    localparam int CW = $clog2(BW + 1);

    logic [PW-1:0] prod_reg, prod_next;
    logic [AW-1:0] a_reg, a_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [AW:0]   sum;

    // One multiplier bit per cycle, LSB first; partial product shifts right.
    always_comb
    begin
        sum       = {1'b0, prod_reg[PW-1:BW]} + (prod_reg[0] ? {1'b0, a_reg} : '0);
        prod_next = prod_reg;
        a_next    = a_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            prod_next = {{AW{1'b0}}, b};
            a_next    = a;
            cnt_next  = CW'(BW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            prod_next = {sum, prod_reg[BW-1:1]};
            cnt_next  = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        a_reg    <= a_next;
    end

    assign busy    = busy_reg;
    assign product = prod_reg;

endmodule

FILE: rtl/core/ept_sdiv.sv
module ept_sdiv #(
    parameter int NW = 32,
    parameter int DW = 20
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [$clog2(NW+1)-1:0]    steps,
    input  logic [DW-1:0]              rem_init,
    input  logic [NW-1:0]              dividend,
    input  logic [DW-1:0]              divisor,
    output logic                       busy,
    output logic [NW-1:0]              quotient,
    output logic [DW-1:0]              remainder
);

    localparam int SW = $clog2(NW + 1);

    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] div_reg, div_next;
    logic [NW-1:0] dsh_reg, dsh_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [SW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [DW:0]   trial;
    logic [DW+1:0] diff;
    logic          fits;

    // Restoring division: shift in one dividend bit MSB first, subtract if it fits.
    always_comb
    begin
        trial     = {rem_reg, dsh_reg[NW-1]};
        diff      = {1'b0, trial} - {2'b00, div_reg};
        fits      = !diff[DW+1];
        rem_next  = rem_reg;
        div_next  = div_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = rem_init;
            div_next  = divisor;
            dsh_next  = dividend;
            quo_next  = '0;
            cnt_next  = steps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DW-1:0] : trial[DW-1:0];
            dsh_next = {dsh_reg[NW-2:0], 1'b0};
            quo_next = {quo_reg[NW-2:0], fits};
            cnt_next = cnt_reg - SW'(1);
            if (cnt_reg == SW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

FILE: rtl/core/encoder_position_speed_tracker_top.sv
// Encoder position and speed tracker, one instance per motor.
// Input channel (in_valid/in_ready/in_data): one transaction per timer tick carries
// the raw encoder counter and a mode bit; MODE_INIT latches the counter and clears
// the running total, MODE_TICK unwraps the counter change and accumulates it.
// Output channel (out_valid/out_ready/out_data): one transaction per input with the
// pulse delta, saturated speed, running total and both angles in centidegrees.
// Configuration: cfg_wr_en writes cfg_wdata into the register selected by cfg_addr
// (speed factor Q8.16, pulses per turn); write only while the block is idle.
// Sequence: each accepted input runs through the serial restoring divider for
// total / pulses_per_turn, then shift-add multiplies of the whole turns and the
// leftover pulses by 36000, then a second division for the single-turn fraction.
// A new input is accepted only once the last result has gone to the output register.
// The speed multiply runs in parallel with the first division.
// Reset: total and previous counter clear to zero, registers take their defaults.
// A tick before any init measures from a previous count of zero.
// Stall: a finished result waits in the output register while the next input is
// accepted; the pipeline holds its last step until out_ready frees that register.
module encoder_position_speed_tracker_top #(
    parameter int COUNTER_BITS = ept_pkg::COUNTER_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  ept_pkg::in_t                    in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output ept_pkg::out_t                   out_data,
    input  logic                            cfg_wr_en,
    input  logic [ept_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [ept_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int CB      = COUNTER_BITS;
    localparam int TW      = ept_pkg::TOTAL_W;
    localparam int PW      = ept_pkg::PPT_W;
    localparam int FW      = ept_pkg::FACTOR_W;
    localparam int AGW     = ept_pkg::ANGLE_W;
    localparam int CDW     = ept_pkg::CDEG_W;
    localparam int SPW     = ept_pkg::SPEED_W;
    localparam int STEP_W  = $clog2(TW + 1);
    localparam int SCALE_W = CB + FW - 16;
    localparam int RPROD_W = PW + CDW;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_ACCUM = 8'b0000_0010,
        ST_LOAD  = 8'b0000_0100,
        ST_DIV1  = 8'b0000_1000,
        ST_MUL   = 8'b0001_0000,
        ST_DIV2  = 8'b0010_0000,
        ST_FIN   = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic [FW-1:0] factor_reg;
    logic [PW-1:0] ppt_reg;
    logic [PW-1:0] ppt_eff;

    // Tracker state and per-item values
    logic [CB-1:0]          prev_reg;
    logic signed [CB-1:0]   delta_reg;
    logic                   mode_reg;
    logic signed [TW-1:0]   total_reg;
    logic [AGW-1:0]         q_reg;
    logic [CDW-1:0]         turn_reg;
    logic signed [SPW-1:0]  speed_reg;

    logic [CB-1:0]          cur;
    logic signed [TW-1:0]   delta_ext;
    logic [CB-1:0]          delta_mag;
    logic                   total_neg;
    logic [TW-1:0]          total_mag;

    // Output register
    ept_pkg::out_t out_data_reg;
    logic          out_valid_reg;
    logic          out_load;

    // Arithmetic units
    logic                 spd_start, spd_busy;
    logic [CB+FW-1:0]     spd_prod;
    logic                 div_start, div_busy;
    logic [STEP_W-1:0]    div_steps;
    logic [PW-1:0]        div_rem_init;
    logic [TW-1:0]        div_dividend;
    logic [TW-1:0]        div_quo;
    logic [PW-1:0]        div_rem;
    logic                 mul_start;
    logic                 kmul_busy, rmul_busy;
    logic [AGW-1:0]       kmul_prod;
    logic [RPROD_W-1:0]   rmul_prod;

    logic [SCALE_W-1:0]   scaled;
    logic signed [SPW-1:0] speed_val;
    logic [CDW-1:0]       frac;
    logic [CDW-1:0]       turn_val;
    logic                 frac_inexact;

    assign ppt_eff   = (ppt_reg == '0) ? PW'(1) : ppt_reg;
    assign cur       = CB'(in_data.counter_value);
    assign delta_ext = TW'(delta_reg);
    assign delta_mag = delta_reg[CB-1] ? (CB'(0) - delta_reg) : delta_reg;
    assign total_neg = total_reg[TW-1];
    assign total_mag = total_neg ? (TW'(0) - total_reg) : total_reg;

    assign in_ready = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg <= ept_pkg::FACTOR_RST;
            ppt_reg    <= ept_pkg::PPT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                ept_pkg::CFG_SPEED_FACTOR:    factor_reg <= cfg_wdata[FW-1:0];
                ept_pkg::CFG_PULSES_PER_TURN: ppt_reg    <= cfg_wdata[PW-1:0];
                default:                      factor_reg <= factor_reg;
            endcase
        end
    end

    // Sequencer: accumulate, divide total, scale by 36000, divide fraction, finish.
    always_comb
    begin
        state_next   = state_reg;
        spd_start    = 1'b0;
        div_start    = 1'b0;
        mul_start    = 1'b0;
        div_steps    = STEP_W'(TW);
        div_rem_init = '0;
        div_dividend = total_mag;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM:
            begin
                spd_start  = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV1;
            end
            ST_DIV1:
            begin
                if (!div_busy)
                begin
                    mul_start  = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                div_steps    = STEP_W'(CDW);
                div_rem_init = rmul_prod[RPROD_W-1:CDW];
                div_dividend = {rmul_prod[CDW-1:0], {(TW-CDW){1'b0}}};
                if (!kmul_busy && !rmul_busy)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV2;
                end
            end
            ST_DIV2:
            begin
                if (!div_busy)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            prev_reg  <= '0;
            total_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_valid && in_ready)
            begin
                prev_reg <= cur;
            end
            // Drop the total on init, otherwise add the sign-extended delta.
            if (state_reg == ST_ACCUM)
            begin
                total_reg <= (mode_reg == ept_pkg::MODE_INIT) ? '0 : total_reg + delta_ext;
            end
        end
    end

    // Capture the unwrapped delta at accept; init reports a zero delta.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mode_reg  <= in_data.mode;
            delta_reg <= (in_data.mode == ept_pkg::MODE_INIT) ? '0 : (cur - prev_reg);
        end
    end

    // Speed: |delta| * factor >> 16, saturated, sign restored.
    assign scaled = spd_prod[CB+FW-1:16];

    always_comb
    begin
        if (delta_reg[CB-1])
        begin
            if (scaled > SCALE_W'(ept_pkg::SPEED_NEG_MAG))
            begin
                speed_val = ept_pkg::SPEED_NEG_SAT;
            end
            else
            begin
                speed_val = SPW'(0) - scaled[SPW-1:0];
            end
        end
        else
        begin
            if (scaled > SCALE_W'(ept_pkg::SPEED_POS_MAX))
            begin
                speed_val = ept_pkg::SPEED_POS_SAT;
            end
            else
            begin
                speed_val = scaled[SPW-1:0];
            end
        end
    end

    // Turn angle: for a negative total the turn is 36000 minus the ceiling of the
    // positive fraction, and zero when the total is a whole number of turns.
    assign frac         = div_quo[CDW-1:0];
    assign frac_inexact = (div_rem != '0);

    always_comb
    begin
        if (!total_neg)
        begin
            turn_val = frac;
        end
        else if (frac == '0 && !frac_inexact)
        begin
            turn_val = '0;
        end
        else
        begin
            turn_val = ept_pkg::CDEG_PER_TURN - frac - CDW'(frac_inexact);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FIN)
        begin
            q_reg     <= kmul_prod + AGW'(frac);
            turn_reg  <= turn_val;
            speed_reg <= speed_val;
        end
    end

    // Output register: hold until taken, load the next result when free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg.pulse_delta      <= delta_ext[ept_pkg::DELTA_W-1:0];
            out_data_reg.shaft_speed      <= speed_reg;
            out_data_reg.total_pulses     <= total_reg;
            out_data_reg.turn_angle_cdeg  <= turn_reg;
            out_data_reg.total_angle_cdeg <= total_neg ? (AGW'(0) - q_reg) : q_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    ept_smul #(
        .AW (CB),
        .BW (FW)
    ) u_spd_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (spd_start),
        .a       (delta_mag),
        .b       (factor_reg),
        .busy    (spd_busy),
        .product (spd_prod)
    );

    ept_sdiv #(
        .NW (TW),
        .DW (PW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .steps     (div_steps),
        .rem_init  (div_rem_init),
        .dividend  (div_dividend),
        .divisor   (ppt_eff),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Whole turns times 36000
    ept_smul #(
        .AW (TW),
        .BW (CDW)
    ) u_kmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (div_quo),
        .b       (ept_pkg::CDEG_PER_TURN),
        .busy    (kmul_busy),
        .product (kmul_prod)
    );

    // Leftover pulses times 36000
    ept_smul #(
        .AW (PW),
        .BW (CDW)
    ) u_rmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (div_rem),
        .b       (ept_pkg::CDEG_PER_TURN),
        .busy    (rmul_busy),
        .product (rmul_prod)
    );

    a_units_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !div_busy && !kmul_busy && !rmul_busy)
        else $error("arithmetic unit busy while idle");

    a_speed_ready: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FIN |-> !spd_busy)
        else $error("speed product not ready at finish");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_ACCUM)
        else $error("accepted transaction did not start accumulation");

    a_init_clears: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ACCUM && mode_reg == ept_pkg::MODE_INIT |=> total_reg == '0)
        else $error("init did not clear the total");

    a_turn_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.turn_angle_cdeg < ept_pkg::CDEG_PER_TURN)
        else $error("turn angle out of range");

endmodule
